FILE: design/brtc_pkg.sv
package brtc_pkg;

  localparam int REG_SPACE = 64;
  localparam int RAM_DEPTH = REG_SPACE - 8;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int PTR_W     = $clog2(REG_SPACE + 1);

  // Item codes carried on the action field.
  typedef enum logic [2:0] {
    ACT_WRITE  = 3'd0,
    ACT_READ   = 3'd1,
    ACT_COMMIT = 3'd2,
    ACT_TICK   = 3'd3,
    ACT_FREEZE = 3'd4
  } action_t;

  // Register map addresses.
  localparam logic [PTR_W-1:0] ADDR_SEC  = PTR_W'(0);
  localparam logic [PTR_W-1:0] ADDR_MIN  = PTR_W'(1);
  localparam logic [PTR_W-1:0] ADDR_HOUR = PTR_W'(2);
  localparam logic [PTR_W-1:0] ADDR_WDAY = PTR_W'(3);
  localparam logic [PTR_W-1:0] ADDR_MDAY = PTR_W'(4);
  localparam logic [PTR_W-1:0] ADDR_MON  = PTR_W'(5);
  localparam logic [PTR_W-1:0] ADDR_YEAR = PTR_W'(6);
  localparam logic [PTR_W-1:0] ADDR_CTRL = PTR_W'(7);
  localparam logic [PTR_W-1:0] ADDR_RAM  = PTR_W'(8);

  // Value of a BCD byte (each nibble taken as it stands, up to 165).
  function automatic logic [7:0] bcd_val(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return 8'((hi << 3) + (hi << 1) + {4'd0, b[3:0]});
  endfunction

  // Two BCD digits of a value below 128, taken modulo 100.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [6:0] r;
    logic [3:0] t;
    r = (v >= 7'd100) ? 7'(v - 7'd100) : v;
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 7'(k * 10)) t = 4'(k);
    end
    return {t, 4'(r - 7'(t * 10))};
  endfunction

  // Contents of the user RAM just after reset.
  function automatic logic [7:0] ram_reset_val(input logic [RAM_AW-1:0] idx);
    logic [7:0] v;
    v = 8'h00;
    if (idx == RAM_AW'(0)) v = 8'h09;
    if (idx == RAM_AW'(1)) v = 8'h07;
    if (idx == RAM_AW'(RAM_DEPTH - 2)) v = 8'h03;
    if (idx == RAM_AW'(RAM_DEPTH - 1)) v = 8'h04;
    return v;
  endfunction

endpackage

FILE: design/bcd_rtc_register_device.sv
// Register-mapped BCD real-time clock with user RAM.
// Input channel (in_valid/in_ready) carries one item a beat: action selects
// a bus byte write (pointer, then data), a bus byte read with auto-increment,
// a commit of the written time, a half-second tick or a snapshot freeze.
// Output channel (out_valid/out_ready) returns exactly one beat per item:
// the byte read (0 for other actions) and the pin and run status after it.
// Each item first issues the user RAM read at the register pointer in the
// accepting cycle, and the following cycle applies the item and loads the
// output register. The RAM read port makes this split necessary, so no new
// item is accepted while the previous one is still executing.
// The next item is accepted once the output register is empty or is being
// taken in the same cycle; a stalled receiver therefore holds off input.
// Synchronous reset sets the time to 00:00:00, day 1, month 1, year 00,
// halts the clock and restores the RAM defaults at once through per-entry
// valid bits, so no clearing pass is needed.
module bcd_rtc_register_device
  import brtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] action,
  input  logic [7:0] wdata,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       pin_level,
  output logic       pin_fast_clock,
  output logic [1:0] rate_select,
  output logic       clock_running
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;

  // Running time in binary.
  logic [5:0] run_sec, run_sec_next;
  logic [5:0] run_min, run_min_next;
  logic [4:0] run_hour, run_hour_next;
  logic [2:0] run_wday, run_wday_next;
  logic [4:0] run_mday, run_mday_next;
  logic [3:0] run_mon, run_mon_next;
  logic [6:0] run_year, run_year_next;
  logic       run_pm, run_pm_next;
  logic       run_twelve, run_twelve_next;
  logic       half_phase, half_phase_next;

  // Readable snapshot and bus state.
  logic [7:0] snap [0:6];
  logic [7:0] snap_next [0:6];
  logic       snap_pm, snap_pm_next;
  logic       snap_twelve, snap_twelve_next;
  logic       halt_flag, halt_flag_next;
  logic [3:0] ctrl, ctrl_next;
  logic [PTR_W-1:0] reg_ptr, reg_ptr_next;
  logic       data_phase, data_phase_next;
  logic       no_data, no_data_next;
  logic       tick_en, tick_en_next;
  logic [3:0] pin_state, pin_state_next;
  logic [7:0] rd_next;

  // Latched item.
  logic [2:0] act_q;
  logic [7:0] wd_q;

  // User RAM with a valid bit per entry.
  logic [7:0]           ram [0:RAM_DEPTH-1];
  logic [RAM_DEPTH-1:0] ram_vld;
  logic [7:0]           ram_q;
  logic                 vld_q;
  logic [RAM_AW-1:0]    ram_idx;
  logic                 ptr_in_ram;
  logic                 ram_we;
  logic [7:0]           ram_rd;

  logic in_fire;

  assign in_ready   = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire    = in_valid && in_ready;
  assign ram_idx    = RAM_AW'(reg_ptr - ADDR_RAM);
  assign ptr_in_ram = (reg_ptr >= ADDR_RAM) && (reg_ptr < PTR_W'(REG_SPACE));
  assign ram_rd     = vld_q ? ram_q : ram_reset_val(ram_idx);
  assign ram_we     = (state == S_EXEC) && (act_q == ACT_WRITE) && data_phase && ptr_in_ram;

  // Memory: read issued at acceptance, write applied in the execute cycle.
  always_ff @(posedge clk) begin
    if (in_fire && ptr_in_ram) begin
      ram_q <= ram[ram_idx];
    end
    if (ram_we) begin
      ram[ram_idx] <= wd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_vld <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (in_fire && ptr_in_ram) vld_q <= ram_vld[ram_idx];
      if (ram_we) ram_vld[ram_idx] <= 1'b1;
    end
  end

  // Item execution.
  always_comb begin
    logic [6:0] s7;
    logic [6:0] m7;
    logic [5:0] h6;
    logic       carry;
    logic [5:0] md6;
    logic [4:0] mo5;
    logic [3:0] wd4;
    logic       leap;
    logic [7:0] v;
    logic [7:0] hb;
    logic       frz;
    logic [5:0] fsec;
    logic [7:0] snap_bin [0:6];

    run_sec_next     = run_sec;
    run_min_next     = run_min;
    run_hour_next    = run_hour;
    run_wday_next    = run_wday;
    run_mday_next    = run_mday;
    run_mon_next     = run_mon;
    run_year_next    = run_year;
    run_pm_next      = run_pm;
    run_twelve_next  = run_twelve;
    half_phase_next  = half_phase;
    for (int i = 0; i < 7; i++) snap_next[i] = snap[i];
    for (int i = 0; i < 7; i++) snap_bin[i] = bcd_val(snap[i]);
    snap_pm_next     = snap_pm;
    snap_twelve_next = snap_twelve;
    halt_flag_next   = halt_flag;
    ctrl_next        = ctrl;
    reg_ptr_next     = reg_ptr;
    data_phase_next  = data_phase;
    no_data_next     = no_data;
    tick_en_next     = tick_en;
    pin_state_next   = pin_state;
    rd_next          = 8'h00;
    s7 = '0; m7 = '0; h6 = '0; carry = 1'b0; md6 = '0; mo5 = '0; wd4 = '0;
    leap = 1'b0; hb = '0; frz = 1'b0; fsec = run_sec;
    v = bcd_val(wd_q);

    case (act_q)
      ACT_WRITE: begin
        if (!data_phase) begin
          if ({1'b0, wd_q} >= 9'(REG_SPACE)) begin
            reg_ptr_next = '0;
          end else begin
            reg_ptr_next    = PTR_W'(wd_q);
            data_phase_next = 1'b1;
          end
          no_data_next = 1'b1;
        end else begin
          case (reg_ptr)
            ADDR_SEC: begin
              halt_flag_next = wd_q[7];
              snap_next[0] = (bcd_val({1'b0, wd_q[6:0]}) > 8'd59) ? 8'h00
                                                                   : {1'b0, wd_q[6:0]};
            end
            ADDR_MIN: snap_next[1] = (v > 8'd59) ? 8'h00 : {1'b0, wd_q[6:0]};
            ADDR_HOUR: begin
              snap_twelve_next = wd_q[6];
              if (!wd_q[6]) begin
                hb = {2'b00, wd_q[5:0]};
                if (bcd_val(hb) > 8'd23) hb = 8'h01;
              end else begin
                hb = {3'b000, wd_q[4:0]};
                if (bcd_val(hb) > 8'd12 || bcd_val(hb) == 8'd0) hb = 8'h01;
              end
              snap_next[2] = hb;
              snap_pm_next = wd_q[5];
            end
            ADDR_WDAY: snap_next[3] = (v > 8'd7 || v == 8'd0) ? 8'h01 : {5'd0, wd_q[2:0]};
            ADDR_MDAY: snap_next[4] = (v > 8'd31 || v == 8'd0) ? 8'h01 : {2'd0, wd_q[5:0]};
            ADDR_MON:  snap_next[5] = (v > 8'd12 || v == 8'd0) ? 8'h01 : {3'd0, wd_q[4:0]};
            ADDR_YEAR: snap_next[6] = (v > 8'd99) ? 8'h99 : wd_q;
            ADDR_CTRL: ctrl_next = {wd_q[7], wd_q[4], wd_q[1:0]};
            default: ;
          endcase
          if (reg_ptr >= PTR_W'(REG_SPACE)) reg_ptr_next = '0;
          else reg_ptr_next = PTR_W'(reg_ptr + 1'b1);
          no_data_next = 1'b0;
        end
      end

      ACT_READ: begin
        case (reg_ptr)
          ADDR_SEC:  rd_next = {halt_flag, snap[0][6:0]};
          ADDR_MIN:  rd_next = {1'b0, snap[1][6:0]};
          ADDR_HOUR: rd_next = snap_twelve ? {2'b01, snap_pm, snap[2][4:0]}
                                           : {2'b00, snap[2][5:0]};
          ADDR_WDAY: rd_next = {5'd0, snap[3][2:0]};
          ADDR_MDAY: rd_next = {2'd0, snap[4][5:0]};
          ADDR_MON:  rd_next = {3'd0, snap[5][4:0]};
          ADDR_YEAR: rd_next = snap[6];
          ADDR_CTRL: rd_next = {ctrl[3], 2'b00, ctrl[2], 2'b00, ctrl[1:0]};
          default:   rd_next = ptr_in_ram ? ram_rd : 8'h00;
        endcase
        if (reg_ptr >= PTR_W'(REG_SPACE - 1)) reg_ptr_next = '0;
        else reg_ptr_next = PTR_W'(reg_ptr + 1'b1);
      end

      ACT_COMMIT: begin
        if (!no_data) begin
          run_sec_next    = snap_bin[0][5:0];
          run_min_next    = snap_bin[1][5:0];
          run_hour_next   = snap_bin[2][4:0];
          run_wday_next   = snap_bin[3][2:0];
          run_mday_next   = snap_bin[4][4:0];
          run_mon_next    = snap_bin[5][3:0];
          run_year_next   = snap_bin[6][6:0];
          run_pm_next     = snap_pm;
          run_twelve_next = snap_twelve;
          if (run_year_next[1:0] != 2'd0 && run_mon_next == 4'd2 && run_mday_next == 5'd29)
            run_mday_next = 5'd28;
          half_phase_next = 1'b0;
          if (!ctrl[2]) pin_state_next = {3'b000, ctrl[3]};
          else if (ctrl[1:0] == 2'd0) pin_state_next = {3'b000, pin_state[0]};
          else pin_state_next = {ctrl[1:0], 1'b1, pin_state[0]};
          tick_en_next = !halt_flag;
        end
      end

      ACT_TICK: begin
        if (tick_en) begin
          half_phase_next = !half_phase;
          if (half_phase) begin
            s7 = 7'({1'b0, run_sec} + 7'd1);
            run_sec_next = s7[5:0];
            if (s7 == 7'd60) begin
              run_sec_next = '0;
              // Snapshot taken with seconds cleared, minute not yet advanced.
              frz  = 1'b1;
              fsec = '0;
              m7 = 7'({1'b0, run_min} + 7'd1);
              run_min_next = m7[5:0];
              if (m7 == 7'd60) begin
                run_min_next = '0;
                h6 = 6'({1'b0, run_hour} + 6'd1);
                if (!run_twelve) begin
                  if (h6 >= 6'd24) begin
                    h6 = '0;
                    carry = 1'b1;
                  end
                end else if (h6 > 6'd12) begin
                  h6 = 6'(h6 - 6'd12);
                  carry = run_pm;
                  run_pm_next = !run_pm;
                end
                run_hour_next = h6[4:0];
                // Day advance.
                if (carry) begin
                  md6  = 6'({1'b0, run_mday} + 6'd1);
                  mo5  = {1'b0, run_mon};
                  wd4  = 4'({1'b0, run_wday} + 4'd1);
                  leap = (run_year[1:0] == 2'd0);
                  if (wd4 == 4'd8) wd4 = 4'd1;
                  if (md6 == 6'd32 ||
                      (md6 == 6'd31 && (mo5 == 5'd4 || mo5 == 5'd6 ||
                                        mo5 == 5'd9 || mo5 == 5'd11)) ||
                      (mo5 == 5'd2 && md6 == 6'd29 && !leap) ||
                      (mo5 == 5'd2 && md6 == 6'd30)) begin
                    md6 = 6'd1;
                    mo5 = 5'(mo5 + 5'd1);
                    if (mo5 == 5'd13) begin
                      mo5 = 5'd1;
                      run_year_next = (run_year >= 7'd99) ? 7'd0 : 7'(run_year + 7'd1);
                    end
                  end
                  run_mday_next = md6[4:0];
                  run_mon_next  = mo5[3:0];
                  run_wday_next = wd4[2:0];
                end
              end
            end
          end
          if (ctrl[2] && ctrl[1:0] == 2'd0)
            pin_state_next = {pin_state[3:1], half_phase_next};
        end
      end

      ACT_FREEZE: frz = 1'b1;

      default: ;
    endcase

    // Freeze of the running time into the BCD snapshot.
    if (frz) begin
      snap_next[0]    = to_bcd({1'b0, fsec});
      snap_next[1]    = to_bcd({1'b0, run_min});
      snap_next[2]    = to_bcd({2'b00, run_hour});
      snap_next[3]    = to_bcd({4'd0, run_wday});
      snap_next[4]    = to_bcd({2'b00, run_mday});
      snap_next[5]    = to_bcd({3'd0, run_mon});
      snap_next[6]    = to_bcd(run_year);
      snap_pm_next    = run_pm;
      data_phase_next = 1'b0;
    end
  end

  // Control, state and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      run_sec     <= '0;
      run_min     <= '0;
      run_hour    <= '0;
      run_wday    <= 3'd1;
      run_mday    <= 5'd1;
      run_mon     <= 4'd1;
      run_year    <= '0;
      run_pm      <= 1'b0;
      run_twelve  <= 1'b0;
      half_phase  <= 1'b0;
      snap[0]     <= 8'h00;
      snap[1]     <= 8'h00;
      snap[2]     <= 8'h00;
      snap[3]     <= 8'h01;
      snap[4]     <= 8'h01;
      snap[5]     <= 8'h01;
      snap[6]     <= 8'h00;
      snap_pm     <= 1'b0;
      snap_twelve <= 1'b0;
      halt_flag   <= 1'b1;
      ctrl        <= '0;
      reg_ptr     <= '0;
      data_phase  <= 1'b0;
      no_data     <= 1'b1;
      tick_en     <= 1'b0;
      pin_state   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_valid && out_ready) out_valid <= 1'b0;
          if (in_fire) state <= S_EXEC;
        end
        S_EXEC: begin
          state       <= S_IDLE;
          out_valid   <= 1'b1;
          run_sec     <= run_sec_next;
          run_min     <= run_min_next;
          run_hour    <= run_hour_next;
          run_wday    <= run_wday_next;
          run_mday    <= run_mday_next;
          run_mon     <= run_mon_next;
          run_year    <= run_year_next;
          run_pm      <= run_pm_next;
          run_twelve  <= run_twelve_next;
          half_phase  <= half_phase_next;
          for (int i = 0; i < 7; i++) snap[i] <= snap_next[i];
          snap_pm     <= snap_pm_next;
          snap_twelve <= snap_twelve_next;
          halt_flag   <= halt_flag_next;
          ctrl        <= ctrl_next;
          reg_ptr     <= reg_ptr_next;
          data_phase  <= data_phase_next;
          no_data     <= no_data_next;
          tick_en     <= tick_en_next;
          pin_state   <= pin_state_next;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item latch and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_q <= action;
      wd_q  <= wdata;
    end
    if (state == S_EXEC) begin
      read_data      <= rd_next;
      pin_level      <= pin_state_next[0];
      pin_fast_clock <= pin_state_next[1];
      rate_select    <= pin_state_next[3:2];
      clock_running  <= tick_en_next;
    end
  end

endmodule
